### design/isc_pkg.sv
// Shared types and codes for the integer stack calculator.
`timescale 1ns / 1ps
`default_nettype none
package isc_pkg;
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_POP  = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_SUB  = 3'd3;
   localparam logic [2:0] OP_MUL  = 3'd4;
   localparam logic [2:0] OP_DIV  = 3'd5;
   localparam logic [2:0] OP_SQRT = 3'd6;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FEW     = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_NEGROOT = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_b;     // capture RAM read data as operand b
      logic load_a;     // capture RAM read data as operand a
      logic start_div;  // initialize the divider
      logic start_sqrt; // initialize the root unit
      logic step;       // one iteration of the shared unit
      logic arith;      // compute the result of the operation (add, sub, mul, div or sqrt)
   } isc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic b_zero;
      logic a_neg;
   } isc_stat_type;
endpackage
`default_nettype wire

### design/isc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module isc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/isc_datapath.sv
// Operand registers, add/sub/mul and the shared iterative divide/root unit.
`timescale 1ns / 1ps
`default_nettype none
module isc_datapath (
   input  wire logic                 clock,
   input  wire isc_pkg::isc_cmd_type cmd,
   input  wire logic [2:0]           op,
   input  wire logic [31:0]          rd_data,
   output isc_pkg::isc_stat_type     stat,
   output logic [31:0]               value
);
   import isc_pkg::*;

   logic [31:0] a_ff, b_ff, rem_ff, quo_ff, res_ff, bit_ff, value_ff;
   logic        neg_ff;
   logic [31:0] rem_in, quo_in, res_in, bit_in, value_in;
   logic [32:0] trial;
   logic [31:0] mag_a, mag_b, rsum;

   assign stat.b_zero = (b_ff == 32'd0);
   assign stat.a_neg  = a_ff[31];
   assign mag_a = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign mag_b = b_ff[31] ? (32'd0 - b_ff) : b_ff;
   assign value = value_ff;
   assign trial = {rem_ff, quo_ff[31]};
   assign rsum  = res_ff + bit_ff;

   // Next values of the shared unit: restoring divide or digit-by-digit root.
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; res_in = res_ff; bit_in = bit_ff;
      value_in = value_ff;
      if (cmd.start_div) begin
         rem_in = 32'd0; quo_in = mag_a;
      end else if (cmd.start_sqrt) begin
         rem_in = a_ff; res_in = 32'd0; bit_in = 32'h4000_0000;
      end else if (cmd.step) begin
         if (op == OP_DIV) begin
            if (trial >= {1'b0, b_ff}) begin
               rem_in = 32'(trial - {1'b0, b_ff});
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end else begin
            if (rem_ff >= rsum) begin
               rem_in = rem_ff - rsum;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
      end
      // The top entry is also offered as the value, which a pop returns.
      if (cmd.load_b) value_in = rd_data;
      if (cmd.arith) begin
         case (op)
            OP_ADD:  value_in = a_ff + b_ff;
            OP_SUB:  value_in = a_ff - b_ff;
            OP_MUL:  value_in = 32'(a_ff * b_ff);
            OP_DIV:  value_in = neg_ff ? (32'd0 - quo_ff) : quo_ff;
            OP_SQRT: value_in = res_ff;
            default: value_in = b_ff;
         endcase
      end
   end

   // Operand and iteration registers; b is replaced by its magnitude at divide start.
   always_ff @(posedge clock) begin
      if (cmd.load_b) b_ff <= rd_data;
      if (cmd.load_a) a_ff <= rd_data;
      if (cmd.start_div) begin
         neg_ff <= a_ff[31] ^ b_ff[31];
         b_ff   <= mag_b;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; res_ff <= res_in; bit_ff <= bit_in;
      value_ff <= value_in;
   end
endmodule
`default_nettype wire

### design/isc_control.sv
// Controller: sequences stack reads, writes and the iterative unit.
`timescale 1ns / 1ps
`default_nettype none
module isc_control #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [2:0]                    req_type,
   input  wire logic [31:0]                   push_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [31:0]                        rsp_result_value,
   output logic [5:0]                         rsp_depth,
   output isc_pkg::isc_cmd_type               cmd,
   output logic [2:0]                         op,
   input  wire isc_pkg::isc_stat_type         stat,
   input  wire logic [31:0]                   value,
   output logic                               wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]     wr_addr,
   output logic [31:0]                        wr_data,
   output logic [$clog2(STACK_DEPTH)-1:0]     rd_addr
);
   import isc_pkg::*;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDB   = 3'd1;
   localparam logic [2:0] S_RDA   = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_ITER  = 3'd4;
   localparam logic [2:0] S_CALC  = 3'd5;
   localparam logic [2:0] S_WB    = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] pv_ff, pv_in;
   logic [4:0]  iter_ff, iter_in;
   logic        rv_ff, rv_in;
   logic [2:0]  st_ff, st_in;
   logic [31:0] val_ff, val_in;
   logic [5:0]  dep_ff, dep_in;

   assign op = op_ff;
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_result_value = val_ff;
   assign rsp_depth = dep_ff;

   // Read address: the top in IDLE, the entry below it otherwise.
   always_comb begin
      if (state_ff == S_IDLE) rd_addr = AW'(count_ff - CW'(1));
      else                    rd_addr = AW'(count_ff - CW'(2));
   end

   // Controller next state and command decode.
   always_comb begin
      state_in = state_ff; count_in = count_ff; op_in = op_ff; pv_in = pv_ff;
      iter_in = iter_ff; rv_in = rv_ff; st_in = st_ff; val_in = val_ff;
      dep_in = dep_ff; cmd = '0; wr_en = 1'b0;
      wr_addr = AW'(count_ff); wr_data = pv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_type; pv_in = push_value;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            // Read of the top was issued in IDLE; check preconditions.
            state_in = S_IDLE; rv_in = 1'b1; val_in = 32'd0; st_in = ST_OK;
            dep_in = 6'(count_ff);
            case (op_ff) inside
               OP_PUSH: begin
                  if (count_ff == CW'(STACK_DEPTH)) st_in = ST_FULL;
                  else begin
                     wr_en = 1'b1; val_in = pv_ff;
                     count_in = count_ff + CW'(1); dep_in = 6'(count_in);
                  end
               end
               OP_POP, OP_SQRT: begin
                  if (count_ff == '0) st_in = ST_FEW;
                  else begin
                     rv_in = 1'b0; cmd.load_b = 1'b1; cmd.load_a = 1'b1;
                     state_in = S_CHECK;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (count_ff < CW'(2)) st_in = ST_FEW;
                  else begin
                     rv_in = 1'b0; cmd.load_b = 1'b1; state_in = S_RDA;
                  end
               end
               default: ;
            endcase
         end
         S_RDA: begin
            cmd.load_a = 1'b1; state_in = S_CHECK;
         end
         S_CHECK: begin
            iter_in = 5'd0; state_in = S_CALC;
            if (op_ff == OP_POP) begin
               rv_in = 1'b1; st_in = ST_OK; val_in = value;
               count_in = count_ff - CW'(1); dep_in = 6'(count_in);
               state_in = S_IDLE;
            end else if (op_ff == OP_DIV && stat.b_zero) begin
               rv_in = 1'b1; st_in = ST_DIVZERO; val_in = 32'd0;
               dep_in = 6'(count_ff); state_in = S_IDLE;
            end else if (op_ff == OP_SQRT && stat.a_neg) begin
               rv_in = 1'b1; st_in = ST_NEGROOT; val_in = 32'd0;
               dep_in = 6'(count_ff); state_in = S_IDLE;
            end else if (op_ff == OP_DIV) begin
               cmd.start_div = 1'b1; state_in = S_ITER;
            end else if (op_ff == OP_SQRT) begin
               cmd.start_sqrt = 1'b1; state_in = S_ITER;
            end
         end
         S_ITER: begin
            cmd.step = 1'b1; iter_in = iter_ff + 5'd1;
            if ((op_ff == OP_DIV && iter_ff == 5'd31) ||
                (op_ff == OP_SQRT && iter_ff == 5'd15)) state_in = S_CALC;
         end
         S_CALC: begin
            cmd.arith = 1'b1; state_in = S_WB;
         end
         S_WB: begin
            // Result replaces the new top.
            wr_en = 1'b1; wr_data = value; rv_in = 1'b1; st_in = ST_OK;
            val_in = value;
            if (op_ff == OP_SQRT) begin
               wr_addr = AW'(count_ff - CW'(1));
            end else begin
               wr_addr = AW'(count_ff - CW'(2));
               count_in = count_ff - CW'(1);
            end
            dep_in = 6'(count_in); state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; pv_ff <= pv_in; iter_ff <= iter_in;
      st_ff <= st_in; val_ff <= val_in; dep_ff <= dep_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rv_ff && st_ff != ST_OK |-> val_ff == 32'd0) else $error("error with value");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !rv_ff) else $error("result while busy");
   a_err_keep: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) && st_ff != ST_OK |-> $stable(count_ff))
      else $error("error changed depth");
`endif
endmodule
`default_nettype wire

### design/integer_stack_calculator.sv
// Top level of the integer stack calculator.
`timescale 1ns / 1ps
`default_nettype none
// Signed 32-bit stack machine of STACK_DEPTH entries held in one RAM. One item
// at a time: divide takes one restoring step per quotient bit in the shared
// iterative unit, and square root one step per root bit pair. The result then
// waits in the output register until transferred, and the next input is taken
// only after that transfer. Each item yields exactly one result.
module integer_stack_calculator #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [31:0] req_push_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_result_value,
   output logic [5:0]       rsp_depth
);
   import isc_pkg::*;
   localparam int AW = $clog2(STACK_DEPTH);

   isc_cmd_type  cmd;
   isc_stat_type stat;
   logic [2:0]   op;
   logic [31:0]  value, wr_data, rd_data;
   logic         wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   isc_control #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .push_value(req_push_value), .rsp_valid, .rsp_ready, .rsp_status,
      .rsp_result_value, .rsp_depth, .cmd, .op, .stat, .value,
      .wr_en, .wr_addr, .wr_data, .rd_addr
   );

   isc_datapath u_dp (
      .clock, .cmd, .op, .rd_data, .stat, .value
   );

   isc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );
endmodule
`default_nettype wire

### tb/integer_stack_calculator_tb.sv
// Self-checking testbench for the integer stack calculator.
`timescale 1ns / 1ps
`default_nettype none
module integer_stack_calculator_tb;
   import isc_pkg::*;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [2:0] OP_NONE = 3'd7;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
      logic [5:0]  depth;
   } calc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [31:0] req_push_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_result_value;
   logic [5:0]  rsp_depth;

   // Predictor state: a private copy of the stack.
   logic [31:0]     model_stack [DEPTH];
   int              model_count = 0;
   calc_result_type pending_results [$];
   int              error_count = 0;
   int              cycle_count = 0;

   integer_stack_calculator #(.STACK_DEPTH(DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_push_value(req_push_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_result_value(rsp_result_value),
      .rsp_depth(rsp_depth)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Floor square root by bitwise digit recurrence.
   function automatic logic [31:0] floor_sqrt(logic [31:0] v);
      logic [31:0] root;
      logic [31:0] bitpos;
      root = 0;
      bitpos = 32'h4000_0000;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v = v - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // Signed division truncating toward zero, wrapped to 32 bits.
   function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // Apply one operation to the private stack and return its result.
   function automatic calc_result_type compute_result(logic [2:0] op, logic [31:0] pv);
      calc_result_type r;
      logic [31:0]     a;
      logic [31:0]     b;
      r = '0;
      case (op)
         OP_PUSH: begin
            if (model_count >= DEPTH) r.status = ST_FULL;
            else begin
               model_stack[model_count] = pv;
               model_count++;
               r.value = pv;
            end
         end
         OP_POP: begin
            if (model_count < 1) r.status = ST_FEW;
            else begin
               model_count--;
               r.value = model_stack[model_count];
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (model_count < 2) r.status = ST_FEW;
            else begin
               b = model_stack[model_count-1];
               a = model_stack[model_count-2];
               case (op)
                  OP_ADD: r.value = a + b;
                  OP_SUB: r.value = a - b;
                  OP_MUL: r.value = a * b;
                  default: begin
                     if (b == 0) r.status = ST_DIVZERO;
                     else r.value = trunc_quotient(a, b);
                  end
               endcase
               if (r.status == ST_OK) begin
                  model_count--;
                  model_stack[model_count-1] = r.value;
               end
            end
         end
         OP_SQRT: begin
            if (model_count < 1) r.status = ST_FEW;
            else if (model_stack[model_count-1][31]) r.status = ST_NEGROOT;
            else begin
               r.value = floor_sqrt(model_stack[model_count-1]);
               model_stack[model_count-1] = r.value;
            end
         end
         default: ;
      endcase
      r.depth = model_count[5:0];
      return r;
   endfunction

   // Short gaps mostly, a long one now and then.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one item; the expectation is queued when the transfer happens.
   // Valid stays high after a transfer so that items can follow back to back.
   task automatic send_item(logic [2:0] op, logic [31:0] pv);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_push_value <= pv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(compute_result(op, pv));
   endtask

   // Stop sending and wait until every expected result has come.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver stalls at random outside of periodic always-ready windows.
   initial begin
      forever begin
         @(posedge clock);
         if (cycle_count % 700 < 150) rsp_ready <= 1'b1;
         else rsp_ready <= (pick_gap() == 0);
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      calc_result_type exp_r;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no expectation waiting");
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_status);
               error_count++;
            end
            if (rsp_result_value !== exp_r.value) begin
               $error("result_value expected %0d actual %0d",
                      $signed(exp_r.value), $signed(rsp_result_value));
               error_count++;
            end
            if (rsp_depth !== exp_r.depth) begin
               $error("depth expected %0d actual %0d", exp_r.depth, rsp_depth);
               error_count++;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Underflow on an empty stack for every consuming operation.
   task automatic test_empty_stack();
      send_item(OP_POP, 32'h0);
      send_item(OP_ADD, 32'h0);
      send_item(OP_SUB, 32'h0);
      send_item(OP_MUL, 32'h0);
      send_item(OP_DIV, 32'h0);
      send_item(OP_SQRT, 32'h0);
      send_item(OP_NONE, 32'hFFFF_FFFF);
   endtask

   // Field extremes and special arithmetic cases.
   task automatic test_arith_corners();
      send_item(OP_PUSH, 32'h7FFF_FFFF);
      send_item(OP_ADD, 32'h0);
      send_item(OP_SQRT, 32'h0);
      send_item(OP_PUSH, 32'h7FFF_FFFF);
      send_item(OP_PUSH, 32'h1);
      send_item(OP_ADD, 32'h0);
      send_item(OP_SQRT, 32'h0);
      send_item(OP_PUSH, 32'h0);
      send_item(OP_DIV, 32'h0);
      send_item(OP_POP, 32'h0);
      send_item(OP_PUSH, 32'hFFFF_FFFF);
      send_item(OP_DIV, 32'h0);
      send_item(OP_PUSH, 32'h0);
      send_item(OP_SUB, 32'h0);
      send_item(OP_PUSH, 32'hFFFF_FFF9);
      send_item(OP_MUL, 32'h0);
      send_item(OP_PUSH, 32'h2);
      send_item(OP_DIV, 32'h0);
      send_item(OP_POP, 32'h0);
      wait_drained();
   endtask

   // Fill to the fixed depth, overflow once, then drain.
   task automatic test_full_stack();
      while (model_count < DEPTH) send_item(OP_PUSH, $urandom());
      send_item(OP_PUSH, 32'h1234_5678);
      send_item(OP_NONE, 32'h0);
      while (model_count > 0) send_item(OP_POP, 32'h0);
   endtask

   // Mostly well-formed sequences with random content, some noise.
   task automatic test_random_mix();
      logic [2:0]  op;
      logic [31:0] pv;
      int          roll;
      for (int i = 0; i < 1750; i++) begin
         roll = $urandom_range(0, 99);
         if (model_count < 2 && roll < 85) op = OP_PUSH;
         else if (model_count > DEPTH - 3 && roll < 60) op = OP_POP;
         else if (roll < 35) op = OP_PUSH;
         else op = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 5))
            0: pv = $urandom_range(0, 15);
            1: pv = 32'($signed($urandom_range(0, 31)) - 16);
            2: pv = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: pv = $urandom();
         endcase
         send_item(op, pv);
         if (i == 900) wait_drained();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_stack();
      test_arith_corners();
      test_full_stack();
      test_random_mix();
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         if (pending_results.size() != 0) $error("expectations left over at end");
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
design/isc_pkg.sv
design/isc_ram.sv
design/isc_datapath.sv
design/isc_control.sv
design/integer_stack_calculator.sv
tb/integer_stack_calculator_tb.sv
